// ===== rtl/core/dnd_pkg.sv =====
// dns name decompressor package: request and response types, status codes
// and size defaults shared by the core and its testbench
// no dependencies
`default_nettype none

package dnd_pkg;

   localparam int PACKET_BYTES_DEF   = 512;
   localparam int MAX_NAME_BYTES_DEF = 255;

   localparam logic [5:0] MAX_HOPS_RESET = 6'd16;

   // length byte tags (top two bits)
   localparam logic [1:0] TAG_LABEL   = 2'b00;
   localparam logic [1:0] TAG_POINTER = 2'b11;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   localparam logic [0:0] MODE_LOAD   = 1'b0;
   localparam logic [0:0] MODE_DECODE = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_HOPS     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [8:0] address;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] text_word;
      logic [3:0]  char_count;
      logic        last;
      logic [8:0]  next_offset;
      logic [1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/dnd_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module dnd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire  [WIDTH-1:0]             wr_data,
   input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dns_name_decompressor_core.sv =====
// dns name decompressor top level: request sequencer around the packet store
// depends on dnd_pkg and dnd_ram
`default_nettype none

// A load request (mode 0) writes one message byte into the packet store; it
// produces no response. A decode request (mode 1) walks the encoded name from
// the given offset, one packet store read per cycle, and streams the dotted
// text as 64-bit words of eight characters, the final word holding the
// remaining zero to seven characters and flagged by last with next_offset and
// status. Each length byte passes through ST_HEAD (issue) and ST_HEAD_WAIT
// (read), each label character through ST_LABEL, and each compression
// pointer also through ST_PTR_WAIT for its low byte.
// busy is high for the whole walk. Responses appear on rsp_strobe for one
// cycle each and cannot be held off; the store read port sets the pace.
// The store holds undefined data until loaded.

module dns_name_decompressor_core #(
   parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
   parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire dnd_pkg::req_type req_item,
   output logic               rsp_strobe,
   output dnd_pkg::rsp_type   rsp_item,
   input  wire                csr_we,
   input  wire  [5:0]         csr_wdata
);

   import dnd_pkg::*;

   localparam int AW     = $clog2(PACKET_BYTES);
   localparam int SUM_W  = $clog2(PACKET_BYTES + 64);
   localparam int CUR_W  = (SUM_W > 14) ? SUM_W : 14;
   localparam logic [CUR_W-1:0] PB_LIM   = CUR_W'(PACKET_BYTES);
   localparam logic [9:0]       NAME_LIM = 10'(MAX_NAME_BYTES);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_HEAD      = 3'd1;
   localparam logic [2:0] ST_HEAD_WAIT = 3'd2;
   localparam logic [2:0] ST_PTR_WAIT  = 3'd3;
   localparam logic [2:0] ST_LABEL     = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic [8:0]       end_ff, end_in;
   logic             jumped_ff, jumped_in;
   logic [5:0]       hop_ff, hop_in;
   logic [7:0]       name_len_ff, name_len_in;
   logic [63:0]      word_ff, word_in;
   logic [3:0]       fill_ff, fill_in;
   logic [5:0]       rem_ff, rem_in;
   logic [5:0]       ptr_hi_ff, ptr_hi_in;
   logic [5:0]       max_hops_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [AW-1:0]    mem_raddr;
   logic [7:0]       mem_rdata;

   logic             char_en;
   logic [7:0]       char_val;
   logic             fin_en;
   logic [1:0]       fin_status;
   logic [8:0]       fin_offset;
   logic [63:0]      word_next;

   logic [CUR_W-1:0] cursor_inc;
   logic [CUR_W-1:0] cursor_plus_len;
   logic [9:0]       name_need;
   logic [CUR_W-1:0] req_addr_ext;

   assign cursor_inc      = cursor_ff + CUR_W'(1);
   assign cursor_plus_len = cursor_ff + CUR_W'(mem_rdata[5:0]);
   assign name_need       = {2'b00, name_len_ff} + {4'b0000, mem_rdata[5:0]} + 10'd2;
   assign req_addr_ext    = CUR_W'(req_item.address);

   dnd_ram #(
      .WIDTH (8),
      .DEPTH (PACKET_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_item.data_byte),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign mem_waddr = req_addr_ext[AW-1:0];

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      end_in      = end_ff;
      jumped_in   = jumped_ff;
      hop_in      = hop_ff;
      name_len_in = name_len_ff;
      rem_in      = rem_ff;
      ptr_hi_in   = ptr_hi_ff;
      mem_we      = 1'b0;
      mem_raddr   = cursor_ff[AW-1:0];
      char_en     = 1'b0;
      char_val    = DOT_CHAR;
      fin_en      = 1'b0;
      fin_status  = STATUS_OK;
      fin_offset  = end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.mode == MODE_LOAD) begin
                  mem_we = (req_addr_ext < PB_LIM);
               end else begin
                  cursor_in   = req_addr_ext;
                  end_in      = 9'd0;
                  jumped_in   = 1'b0;
                  hop_in      = 6'd0;
                  name_len_in = 8'd0;
                  state_in    = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (cursor_ff >= PB_LIM) begin
               fin_en     = 1'b1;
               fin_status = STATUS_OVERFLOW;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_HEAD_WAIT;
            end
         end
         ST_HEAD_WAIT: begin
            mem_raddr = cursor_inc[AW-1:0];
            if (mem_rdata == 8'd0) begin
               fin_en = 1'b1;
               if (!jumped_ff) begin
                  fin_offset = cursor_inc[8:0];
               end
               state_in = ST_IDLE;
            end else if (mem_rdata[7:6] == TAG_POINTER) begin
               if (cursor_inc >= PB_LIM) begin
                  fin_en     = 1'b1;
                  fin_status = STATUS_OVERFLOW;
                  state_in   = ST_IDLE;
               end else if (hop_ff >= max_hops_ff) begin
                  fin_en     = 1'b1;
                  fin_status = STATUS_HOPS;
                  state_in   = ST_IDLE;
               end else begin
                  if (!jumped_ff) begin
                     end_in    = 9'(cursor_ff + CUR_W'(2));
                     jumped_in = 1'b1;
                  end
                  hop_in    = hop_ff + 6'd1;
                  ptr_hi_in = mem_rdata[5:0];
                  state_in  = ST_PTR_WAIT;
               end
            end else if (mem_rdata[7:6] != TAG_LABEL) begin
               fin_en     = 1'b1;
               fin_status = STATUS_BAD_TYPE;
               state_in   = ST_IDLE;
            end else if (name_need > NAME_LIM || cursor_plus_len >= PB_LIM) begin
               fin_en     = 1'b1;
               fin_status = STATUS_OVERFLOW;
               state_in   = ST_IDLE;
            end else begin
               // separator before every label but the first
               char_en     = (name_len_ff != 8'd0);
               name_len_in = name_len_ff + {2'b00, mem_rdata[5:0]} + 8'd1;
               rem_in      = mem_rdata[5:0];
               cursor_in   = cursor_inc;
               state_in    = ST_LABEL;
            end
         end
         ST_PTR_WAIT: begin
            cursor_in = CUR_W'({ptr_hi_ff, mem_rdata});
            state_in  = ST_HEAD;
         end
         ST_LABEL: begin
            mem_raddr = cursor_inc[AW-1:0];
            char_en   = 1'b1;
            char_val  = mem_rdata;
            cursor_in = cursor_inc;
            rem_in    = rem_ff - 6'd1;
            if (rem_ff == 6'd1) begin
               state_in = ST_HEAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // character packing and response formation
   always_comb begin
      word_in       = word_ff;
      fill_in       = fill_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      word_next     = word_ff | (64'(char_val) << {fill_ff[2:0], 3'b000});

      if (state_ff == ST_IDLE) begin
         word_in = 64'd0;
         fill_in = 4'd0;
      end

      if (char_en) begin
         if (fill_ff[2:0] == 3'd7) begin
            rsp_in.text_word   = word_next;
            rsp_in.char_count  = 4'd8;
            rsp_in.last        = 1'b0;
            rsp_in.next_offset = 9'd0;
            rsp_in.status      = STATUS_OK;
            rsp_strobe_in      = 1'b1;
            word_in            = 64'd0;
            fill_in            = 4'd0;
         end else begin
            word_in = word_next;
            fill_in = fill_ff + 4'd1;
         end
      end

      if (fin_en) begin
         rsp_in.text_word   = word_ff;
         rsp_in.char_count  = fill_ff;
         rsp_in.last        = 1'b1;
         rsp_in.next_offset = (fin_status == STATUS_OK) ? fin_offset : 9'd0;
         rsp_in.status      = fin_status;
         rsp_strobe_in      = 1'b1;
         word_in            = 64'd0;
         fill_in            = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_ff     <= '0;
         end_ff        <= 9'd0;
         jumped_ff     <= 1'b0;
         hop_ff        <= 6'd0;
         name_len_ff   <= 8'd0;
         word_ff       <= 64'd0;
         fill_ff       <= 4'd0;
         rem_ff        <= 6'd0;
         max_hops_ff   <= MAX_HOPS_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         end_ff        <= end_in;
         jumped_ff     <= jumped_in;
         hop_ff        <= hop_in;
         name_len_ff   <= name_len_in;
         word_ff       <= word_in;
         fill_ff       <= fill_in;
         rem_ff        <= rem_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            max_hops_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_hi_ff <= ptr_hi_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/tb_dns_name_decompressor_core.sv =====
// testbench for dns_name_decompressor_core: directed table then random load and decode traffic,
// every response word checked against the directed table or an in-bench name decoder with its own packet store copy
// depends on dnd_pkg and dns_name_decompressor_core
`default_nettype none

module tb_dns_name_decompressor_core;
   import dnd_pkg::*;

   localparam int STORE_BYTES     = PACKET_BYTES_DEF;
   localparam int NAME_AREA_BASE  = 40;
   localparam int MAX_WORDS       = 32;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int LAST_PHASE      = 6;
   localparam int CFG_SETTLE      = 4;
   localparam int END_SETTLE      = 400;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam int DIRECTED_ROWS   = 25;

   // typed rows always expect one empty final word, so only next_offset and status are listed
   typedef struct packed {
      logic       mode;
      logic [8:0] address;
      logic [7:0] data_byte;
      logic       typed;
      logic [8:0] want_next;
      logic [1:0] want_status;
   } directed_row_type;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{MODE_LOAD,   9'd0,   8'h00, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd0,   8'h00, 1'b1, 9'd1, STATUS_OK},       // root name
      '{MODE_LOAD,   9'd511, 8'h00, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd511, 8'hff, 1'b1, 9'd0, STATUS_OK},       // next offset wraps
      '{MODE_LOAD,   9'd510, 8'hc0, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd510, 8'h00, 1'b1, 9'd0, STATUS_OK},       // pointer to root, wraps
      '{MODE_LOAD,   9'd511, 8'hc0, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd511, 8'h00, 1'b1, 9'd0, STATUS_OVERFLOW}, // pointer cut by store end
      '{MODE_LOAD,   9'd12,  8'hc2, 1'b0, 9'd0, STATUS_OK},
      '{MODE_LOAD,   9'd13,  8'h00, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd12,  8'h00, 1'b1, 9'd0, STATUS_OVERFLOW}, // target just past store
      '{MODE_LOAD,   9'd10,  8'h40, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd10,  8'h00, 1'b1, 9'd0, STATUS_BAD_TYPE},
      '{MODE_LOAD,   9'd11,  8'hbf, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd11,  8'h00, 1'b1, 9'd0, STATUS_BAD_TYPE},
      '{MODE_LOAD,   9'd508, 8'h05, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd508, 8'h00, 1'b1, 9'd0, STATUS_OVERFLOW}, // label runs off the store
      '{MODE_LOAD,   9'd20,  8'hc0, 1'b0, 9'd0, STATUS_OK},
      '{MODE_LOAD,   9'd21,  8'h14, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd20,  8'h00, 1'b1, 9'd0, STATUS_HOPS},     // pointer to itself
      '{MODE_LOAD,   9'd22,  8'h01, 1'b0, 9'd0, STATUS_OK},
      '{MODE_LOAD,   9'd23,  8'hff, 1'b0, 9'd0, STATUS_OK},
      '{MODE_LOAD,   9'd24,  8'h00, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd22,  8'h00, 1'b0, 9'd0, STATUS_OK},
      '{MODE_DECODE, 9'd23,  8'h00, 1'b1, 9'd0, STATUS_OVERFLOW}  // pointer target far past the store
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_we = 1'b0;
   logic [5:0] csr_wdata = '0;

   dns_name_decompressor_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder state kept alongside the block
   logic [7:0]  packet_mirror [STORE_BYTES];
   bit          loaded [STORE_BYTES];
   logic [5:0]  hop_limit = MAX_HOPS_RESET;
   logic [63:0] word_acc;
   int          word_len;
   rsp_type     name_words [$];
   rsp_type     expected_words [$];

   int  name_heads [$];
   int  free_at = NAME_AREA_BASE;
   bit  idle_on = 1'b1;
   int  requests_sent = 0;
   int  decodes_sent = 0;
   int  words_checked = 0;
   int  error_count = 0;
   int  status_tally [4];

   function automatic void flush_word(logic lst, logic [8:0] nxt, logic [1:0] st);
      rsp_type w;
      w.text_word   = word_acc;
      w.char_count  = 4'(word_len);
      w.last        = lst;
      w.next_offset = nxt;
      w.status      = st;
      if (name_words.size() < MAX_WORDS)
         name_words.push_back(w);
      word_acc = '0;
      word_len = 0;
   endfunction

   function automatic void add_char(logic [7:0] c);
      word_acc[8*word_len +: 8] = c;
      word_len++;
      if (word_len == 8)
         flush_word(1'b0, 9'd0, STATUS_OK);
   endfunction

   // walks the name at from into name_words; returns -1, or the first unloaded byte it
   // would have to read (name_words is then meaningless)
   function automatic int predict_name(int from);
      int cursor, end_ofs, hops, nlen, len, i;
      bit jumped;
      logic [1:0] st;
      logic [7:0] lb;
      name_words.delete();
      word_acc = '0;
      word_len = 0;
      cursor   = from;
      end_ofs  = 0;
      hops     = 0;
      nlen     = 0;
      jumped   = 1'b0;
      st       = STATUS_OK;
      while (1) begin
         if (cursor >= STORE_BYTES) begin
            st = STATUS_OVERFLOW;
            break;
         end
         if (!loaded[cursor])
            return cursor;
         lb  = packet_mirror[cursor];
         len = int'(lb);
         if (lb == 8'h00) begin
            if (!jumped)
               end_ofs = cursor + 1;
            break;
         end
         if (lb[7:6] == TAG_POINTER) begin
            if (cursor + 1 >= STORE_BYTES) begin
               st = STATUS_OVERFLOW;
               break;
            end
            if (hops >= hop_limit) begin
               st = STATUS_HOPS;
               break;
            end
            if (!loaded[cursor + 1])
               return cursor + 1;
            if (!jumped) begin
               end_ofs = cursor + 2;
               jumped  = 1'b1;
            end
            hops++;
            cursor = int'({lb[5:0], packet_mirror[cursor + 1]});
            continue;
         end
         if (lb[7:6] != TAG_LABEL) begin
            st = STATUS_BAD_TYPE;
            break;
         end
         // length bytes, label bytes and the closing zero must fit the name limit
         if (nlen + len + 2 > MAX_NAME_BYTES_DEF || cursor + len >= STORE_BYTES) begin
            st = STATUS_OVERFLOW;
            break;
         end
         for (i = 1; i <= len; i++)
            if (!loaded[cursor + i])
               return cursor + i;
         if (nlen > 0)
            add_char(DOT_CHAR);
         for (i = 1; i <= len; i++)
            add_char(packet_mirror[cursor + i]);
         nlen   += len + 1;
         cursor += len + 1;
      end
      flush_word(1'b1, (st == STATUS_OK) ? end_ofs[8:0] : 9'd0, st);
      return -1;
   endfunction

   function automatic logic [7:0] filler_byte();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'($urandom_range(1, 12));
         2: return {TAG_POINTER, 6'($urandom_range(0, 1))};
         default: return 8'($urandom());
      endcase
   endfunction

   // keeps start high across back-to-back requests, drops it only for an idle burst
   task automatic send_request(req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   task automatic put_byte(int at, logic [7:0] value);
      req_type r;
      r.mode      = MODE_LOAD;
      r.address   = at[8:0];
      r.data_byte = value;
      send_request(r);
      packet_mirror[at] = value;
      loaded[at]        = 1'b1;
   endtask

   // bytes the walk would read but that were never loaded get filler first
   task automatic decode_at(int from);
      int gap;
      req_type r;
      gap = predict_name(from);
      while (gap >= 0) begin
         put_byte(gap, filler_byte());
         gap = predict_name(from);
      end
      r.mode      = MODE_DECODE;
      r.address   = from[8:0];
      r.data_byte = 8'($urandom());
      send_request(r);
      foreach (name_words[k])
         expected_words.push_back(name_words[k]);
      decodes_sent++;
      status_tally[name_words[name_words.size() - 1].status]++;
   endtask

   // lays out one encoded name in the store and decodes it
   task automatic write_name();
      int sizes [3];
      int labels, total, at, head, i, k, pick;
      labels = $urandom_range(1, 3);
      total  = 2;
      for (i = 0; i < labels; i++) begin
         sizes[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
         total += sizes[i] + 1;
      end
      if (free_at + total > STORE_BYTES)
         free_at = NAME_AREA_BASE;
      head = free_at;
      at   = head;
      for (i = 0; i < labels; i++) begin
         name_heads.push_back(at);
         put_byte(at, 8'(sizes[i]));
         at++;
         for (k = 0; k < sizes[i]; k++) begin
            put_byte(at, 8'($urandom()));
            at++;
         end
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            put_byte(at, 8'h00);
         end
         5, 6, 7: begin
            pick = name_heads[$urandom_range(0, name_heads.size() - 1)];
            put_byte(at, {TAG_POINTER, 6'(pick >> 8)});
            put_byte(at + 1, pick[7:0]);
         end
         8: begin
            // loops back to its own start: long text, then hop limit or length overflow
            put_byte(at, {TAG_POINTER, 6'(head >> 8)});
            put_byte(at + 1, head[7:0]);
         end
         default: begin
            put_byte(at, 8'($urandom_range(8'h40, 8'hbf)));
         end
      endcase
      free_at = at + 2;
      decode_at(head);
   endtask

   task automatic set_hop_limit(logic [5:0] value);
      start <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0 || busy);
      repeat (CFG_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      hop_limit = value;
   endtask

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_words.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_item);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_item.text_word !== want.text_word) begin
               $error("text_word expected %h got %h", want.text_word, rsp_item.text_word);
               error_count++;
            end
            if (rsp_item.char_count !== want.char_count) begin
               $error("char_count expected %0d got %0d", want.char_count, rsp_item.char_count);
               error_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last expected %0b got %0b", want.last, rsp_item.last);
               error_count++;
            end
            if (rsp_item.next_offset !== want.next_offset) begin
               $error("next_offset expected %0d got %0d", want.next_offset,
                      rsp_item.next_offset);
               error_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_item.status);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe === 1'b1)
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      directed_row_type row;
      req_type r;
      rsp_type want;
      int n, phase, phase_end;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = DIRECTED[n];
         if (row.mode == MODE_LOAD) begin
            put_byte(int'(row.address), row.data_byte);
         end else if (row.typed) begin
            r.mode      = MODE_DECODE;
            r.address   = row.address;
            r.data_byte = row.data_byte;
            send_request(r);
            want.text_word   = '0;
            want.char_count  = '0;
            want.last        = 1'b1;
            want.next_offset = row.want_next;
            want.status      = row.want_status;
            expected_words.push_back(want);
            decodes_sent++;
            status_tally[row.want_status]++;
         end else begin
            decode_at(int'(row.address));
         end
      end

      for (phase = 0; phase <= LAST_PHASE; phase++) begin
         case (phase)
            0: ;                                   // reset value
            1, 4: set_hop_limit(6'd1);
            2, 6: set_hop_limit(6'd63);
            default: set_hop_limit(6'($urandom_range(2, 62)));
         endcase
         idle_on   = (phase != LAST_PHASE);
         phase_end = requests_sent + ITEMS_PER_PHASE;
         while (requests_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1: write_name();
               2, 3, 4, 5, 6: begin
                  if (name_heads.size() == 0)
                     write_name();
                  else
                     decode_at(name_heads[$urandom_range(0, name_heads.size() - 1)]);
               end
               7: decode_at($urandom_range(0, STORE_BYTES - 1));
               8: decode_at($urandom_range(STORE_BYTES - 32, STORE_BYTES - 1));
               default: put_byte($urandom_range(0, STORE_BYTES - 1), filler_byte());
            endcase
         end
      end

      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      $display("covered %0d requests, %0d name decodes, %0d response words, hop limits 1 to 63",
               requests_sent, decodes_sent, words_checked);
      $display("decode endings ok %0d, hop limit %0d, overflow %0d, bad label %0d",
               status_tally[STATUS_OK], status_tally[STATUS_HOPS],
               status_tally[STATUS_OVERFLOW], status_tally[STATUS_BAD_TYPE]);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
